/* rtl/lsws_pkg.sv */
// ----------------------------------------------------------------------------
// LIFO stack with search: shared package
// Sizes, operation and error codes, controller states and the control bundle
// that the top level drives into every stack cell.
// ----------------------------------------------------------------------------
package lsws_pkg;

    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 8;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SIZE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int ERR_W      = 2;
    localparam int GROUP      = 8;
    localparam int NGROUP     = (DEPTH + GROUP - 1) / GROUP;

    typedef enum logic [KIND_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CHECK = 2'd2
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic [DATA_WIDTH-1:0] key;
    } t_cell_ctrl;

endpackage

/* rtl/lsws_if.sv */
// ----------------------------------------------------------------------------
// LIFO stack with search: channel interfaces
// Request channel carries the operation and value, result channel carries
// the stack status after each operation.
// ----------------------------------------------------------------------------
interface lsws_in_if;
    logic                            valid;
    logic                            ready;
    logic [lsws_pkg::KIND_W-1:0]     kind;
    logic [lsws_pkg::DATA_WIDTH-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface lsws_out_if;
    logic                            valid;
    logic                            ready;
    logic [lsws_pkg::DATA_WIDTH-1:0] top_value;
    logic                            top_valid;
    logic                            found;
    logic [lsws_pkg::SIZE_W-1:0]     size;
    logic                            is_empty;
    logic [lsws_pkg::ERR_W-1:0]      error;

    modport source (output valid, output top_value, output top_valid, output found,
                    output size, output is_empty, output error, input ready);
    modport sink   (input valid, input top_value, input top_valid, input found,
                    input size, input is_empty, input error, output ready);
endinterface

/* rtl/lsws_cell.sv */
// ----------------------------------------------------------------------------
// LIFO stack with search: stack cell
// Holds one entry, shifts toward the bottom on a push and toward the top on
// a pop, and registers whether its entry matches the search key.
// ----------------------------------------------------------------------------
module lsws_cell (
    input  logic                            i_clk,
    input  lsws_pkg::t_cell_ctrl            i_ctrl,
    input  logic [lsws_pkg::DATA_WIDTH-1:0] i_from_up,
    input  logic [lsws_pkg::DATA_WIDTH-1:0] i_from_down,
    input  logic                            i_held,
    output logic [lsws_pkg::DATA_WIDTH-1:0] o_data,
    output logic                            o_match
);
    import lsws_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_data <= i_from_up;
        end else if (i_ctrl.pop) begin
            r_data <= i_from_down;
        end
        r_match <= i_held && (r_data == i_ctrl.key);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

/* rtl/lsws_or_tree.sv */
// ----------------------------------------------------------------------------
// LIFO stack with search: match reduction
// Registers the OR of each group of cell match flags; the final OR over the
// group registers is left to the consumer's output register.
// ----------------------------------------------------------------------------
module lsws_or_tree (
    input  logic                       i_clk,
    input  logic [lsws_pkg::DEPTH-1:0] i_bits,
    output logic                       o_any
);
    import lsws_pkg::*;

    logic [NGROUP-1:0] r_group;
    logic [NGROUP-1:0] n_group;

    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            n_group[g] = 1'b0;
            for (int b = 0; b < GROUP; b++) begin
                if (g * GROUP + b < DEPTH) begin
                    n_group[g] = n_group[g] | i_bits[g * GROUP + b];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_group <= n_group;
    end

    assign o_any = |r_group;

endmodule

/* rtl/lifo_stack_with_search_unit.sv */
// ----------------------------------------------------------------------------
// LIFO stack with search: top level
// Shift-register stack built from a row of cells, top entry in cell zero,
// with a registered membership search over all held entries.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// i_in      request    kind (push, pop, check), value
// o_out     result     top_value, top_valid, found, size, is_empty, error
//
// A new push, pop or no-op request is taken every cycle while idle and unstalled.
// A check goes through cell compare, group reduction and final OR, in order.
// Reset clears the fill count and the controller; entries are never cleared.
// The result register holds a finished transaction while the next is taken,
// as long as it is being accepted downstream in the same cycle.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsws_in_if.sink     i_in,
    lsws_out_if.source  o_out
);
    import lsws_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_top;
    logic                  r_found;
    logic [CNT_W-1:0]      r_size;
    t_err                  r_err;

    logic [DATA_WIDTH-1:0] n_top;
    logic                  n_found;
    t_err                  n_err;
    logic                  w_load;
    logic                  w_accept;
    logic                  w_any;
    logic [DATA_WIDTH-1:0] w_top_now;
    t_cell_ctrl            w_ctrl;

    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]      w_match;
    logic [DEPTH-1:0]      w_held;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_up;
        logic [DATA_WIDTH-1:0] w_down;

        if (i == 0) begin : g_first
            assign w_up = i_in.value;
        end else begin : g_mid_up
            assign w_up = w_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_down = '0;
        end else begin : g_mid_down
            assign w_down = w_data[i+1];
        end

        assign w_held[i] = CNT_W'(i) < r_count;

        lsws_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .i_held      (w_held[i]),
            .o_data      (w_data[i]),
            .o_match     (w_match[i])
        );
    end

    lsws_or_tree u_or_tree (
        .i_clk  (i_clk),
        .i_bits (w_match),
        .o_any  (w_any)
    );

    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_top_now  = (r_count != '0) ? w_data[0] : '0;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top       = w_top_now;
        n_found     = 1'b0;
        n_err       = ERR_NONE;
        w_load      = 1'b0;
        w_ctrl.push = 1'b0;
        w_ctrl.pop  = 1'b0;
        w_ctrl.key  = i_in.value;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.kind)
                        OP_PUSH: begin
                            w_load = 1'b1;
                            if (r_count >= CNT_W'(DEPTH)) begin
                                n_err = ERR_FULL;
                            end else begin
                                w_ctrl.push = 1'b1;
                                n_count     = r_count + CNT_W'(1);
                                n_top       = i_in.value;
                            end
                        end
                        OP_POP: begin
                            w_load = 1'b1;
                            if (r_count == '0) begin
                                n_err = ERR_EMPTY;
                            end else begin
                                w_ctrl.pop = 1'b1;
                                n_count    = r_count - CNT_W'(1);
                                n_top      = (r_count > CNT_W'(1)) ? w_data[1] : '0;
                            end
                        end
                        OP_CHECK: begin
                            n_state = ST_REDUCE;
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_REDUCE: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                w_load  = 1'b1;
                n_found = w_any;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_top   <= n_top;
            r_found <= n_found;
            r_size  <= n_count;
            r_err   <= n_err;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.top_value = r_top;
    assign o_out.top_valid = (r_size != '0);
    assign o_out.found     = r_found;
    assign o_out.size      = SIZE_W'(r_size);
    assign o_out.is_empty  = (r_size == '0);
    assign o_out.error     = r_err;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Fill count exceeds the stack depth.");

    a_check_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.kind == OP_CHECK)) |-> ##2 (w_load && r_state == ST_FINISH))
        else $error("Check transaction did not finish after the reduction.");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.kind == OP_PUSH) && (r_count < CNT_W'(DEPTH)))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("Accepted push did not raise the fill count.");

    a_pop_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.kind == OP_POP) && (r_count == '0))
        |=> (r_count == '0 && r_err == ERR_EMPTY && r_out_valid))
        else $error("Pop on an empty stack was not refused.");

endmodule

/* tb/lifo_stack_with_search_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack with search: regression testbench
// Drives push, pop, membership-check and unused requests into the stack. The
// sender works in bursts with gaps, and the receiver stalls on a schedule of
// its own. A tracker keeps its own copy of the stack, predicts the status
// after every accepted request and compares each result transaction with it,
// field by field. Fill and drain phases take the stack to full and to empty.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_unit_test;
    import lsws_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;

    localparam logic [KIND_W-1:0] OP_UNUSED = 2'b11;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] top_value;
        logic                  top_valid;
        logic                  found;
        logic [SIZE_W-1:0]     size;
        logic                  is_empty;
        t_err                  error;
    } t_stack_status;

    class t_status_tracker;
        logic [DATA_WIDTH-1:0] held [DEPTH];
        int unsigned           fill;
        t_stack_status         status_due_q[$];
        int unsigned           fail_count;

        function new();
            fill       = 0;
            fail_count = 0;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [DATA_WIDTH-1:0] value);
            t_stack_status s;
            s       = '0;
            s.error = ERR_NONE;
            case (kind)
                OP_PUSH: begin
                    if (fill >= DEPTH) begin
                        s.error = ERR_FULL;
                    end else begin
                        held[fill] = value;
                        fill++;
                    end
                end
                OP_POP: begin
                    if (fill == 0) begin
                        s.error = ERR_EMPTY;
                    end else begin
                        fill--;
                    end
                end
                OP_CHECK: begin
                    for (int i = 0; i < fill; i++) begin
                        if (held[i] == value) begin
                            s.found = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (fill > 0) begin
                s.top_value = held[fill - 1];
            end
            s.top_valid = (fill > 0);
            s.size      = fill[SIZE_W-1:0];
            s.is_empty  = (fill == 0);
            status_due_q.push_back(s);
        endfunction

        function void check_status(t_stack_status got);
            t_stack_status exp;
            if (status_due_q.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result: top=%0d/%0b found=%0b size=%0d empty=%0b err=%0d",
                             got.top_value, got.top_valid, got.found, got.size,
                             got.is_empty, got.error);
                end
                fail_count++;
                return;
            end
            exp = status_due_q.pop_front();
            if (got.top_value !== exp.top_value || got.top_valid !== exp.top_valid ||
                got.found !== exp.found || got.size !== exp.size ||
                got.is_empty !== exp.is_empty || got.error !== exp.error) begin
                if (fail_count < 10) begin
                    $display("status mismatch: expected top=%0d/%0b found=%0b size=%0d empty=%0b err=%0d",
                             exp.top_value, exp.top_valid, exp.found, exp.size,
                             exp.is_empty, exp.error);
                    $display("                 actual   top=%0d/%0b found=%0b size=%0d empty=%0b err=%0d",
                             got.top_value, got.top_valid, got.found, got.size,
                             got.is_empty, got.error);
                end
                fail_count++;
            end
        endfunction

        function int unsigned pending();
            return status_due_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;

    lsws_in_if  in_if ();
    lsws_out_if out_if ();

    lifo_stack_with_search_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_status_tracker     tracker;
    int unsigned         cycle_count = 0;
    int                  burst_left  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        case (cycle_count[9:8])
            2'd0:    out_if.ready <= 1'b1;
            2'd1:    out_if.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_if.ready <= ($urandom_range(0, 2) == 0);
            default: out_if.ready <= (cycle_count[3:0] < 4'd11);
        endcase
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            tracker.check_status(t_stack_status'{out_if.top_value, out_if.top_valid,
                                                 out_if.found, out_if.size,
                                                 out_if.is_empty, t_err'(out_if.error)});
        end
    end

    task automatic issue(input logic [KIND_W-1:0] kind, input logic [DATA_WIDTH-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.kind  <= kind;
        in_if.value <= value;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.note_request(kind, value);
    endtask

    task automatic random_item(input int push_w, input int pop_w, input int check_w);
        int                    roll;
        logic [KIND_W-1:0]     kind;
        logic [DATA_WIDTH-1:0] value;
        roll = $urandom_range(0, push_w + pop_w + check_w + 1);
        if (roll < push_w) begin
            kind = OP_PUSH;
        end else if (roll < push_w + pop_w) begin
            kind = OP_POP;
        end else if (roll < push_w + pop_w + check_w) begin
            kind = OP_CHECK;
        end else begin
            kind = OP_UNUSED;
        end
        if (kind == OP_CHECK && tracker.fill > 0 && $urandom_range(0, 1) == 0) begin
            value = tracker.held[$urandom_range(0, tracker.fill - 1)];
        end else if ($urandom_range(0, 3) == 0) begin
            value = DATA_WIDTH'($urandom_range(0, 15));
        end else begin
            value = DATA_WIDTH'($urandom_range(0, 255));
        end
        issue(kind, value);
    endtask

    task automatic wait_all_results();
        in_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    initial begin
        tracker = new();
        in_if.valid  <= 1'b0;
        in_if.kind   <= OP_PUSH;
        in_if.value  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(OP_CHECK,  8'h00);
        issue(OP_POP,    8'hFF);
        issue(OP_UNUSED, 8'hA5);
        issue(OP_PUSH,   8'h00);
        issue(OP_PUSH,   8'hFF);
        issue(OP_CHECK,  8'hFF);
        issue(OP_CHECK,  8'h00);
        issue(OP_CHECK,  8'h5A);
        issue(OP_UNUSED, 8'h5A);
        issue(OP_PUSH,   8'h80);
        issue(OP_PUSH,   8'h01);
        issue(OP_PUSH,   8'h01);
        issue(OP_CHECK,  8'h01);
        issue(OP_POP,    8'hFF);
        issue(OP_POP,    8'h00);
        issue(OP_CHECK,  8'h80);
        issue(OP_POP,    8'h55);
        issue(OP_POP,    8'hAA);
        issue(OP_POP,    8'h00);
        issue(OP_CHECK,  8'hFF);

        repeat (120) random_item(45, 25, 25);
        wait_all_results();
        while (tracker.fill < DEPTH) random_item(85, 5, 10);
        repeat (12) random_item(80, 5, 15);
        wait_all_results();
        while (tracker.fill > 0) random_item(5, 85, 10);
        repeat (12) random_item(10, 80, 10);
        repeat (100) random_item(35, 35, 28);

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.fail_count == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
